// ----- rtl/ort_pkg.sv -----
// Shared definitions for the outstanding request tracker.
// Holds the operation codes carried with each request; no dependencies.
package ort_pkg;

  typedef enum logic [1:0] {
    OP_POST = 2'd0,
    OP_TAKE = 2'd1,
    OP_RESP = 2'd2,
    OP_FREE = 2'd3
  } op_t;

  localparam int unsigned SLOT_OUT_BITS = 6;

endpackage

// ----- rtl/ort_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for every table of the outstanding request tracker; no dependencies.
module ort_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ----- rtl/outstanding_request_tracker.sv -----
// Outstanding request tracker: slot table of remote-memory requests.
// Depends on ort_pkg and ort_ram.
//
// Usage: each request enters on the in_ channel (in_tuser = operation, in_tdata =
// connection, sequence number, expect flag and slot) and produces exactly one
// result on the out_ channel (out_tdata = slot, out_tuser = success).
// Operations: post takes the oldest free slot, take-next moves the oldest
// posted slot to the sent list, response matches the oldest sent slot with equal
// connection, sequence and flag, free returns a responded slot to the free list.
// One request is worked on at a time. A response searches the sent entries
// from the oldest, then moves the younger entries down to close the gap after
// a match; each entry costs one read of the sent-list RAM. The next request is
// accepted once the result is registered. After reset a clearing pass over
// every slot resets the per-slot status RAM; in_tready stays low meanwhile.
// If the receiver stalls, the finished result waits in the output register
// and one more request may be worked on, which then waits until the output
// register is free.
module outstanding_request_tracker #(
  parameter int unsigned SLOTS     = 64,
  parameter int unsigned SEQ_BITS  = 22,
  parameter int unsigned CONN_BITS = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // conn_id, seq_number, expects_message, slot_in (from the lowest bit), zero padded
  input  logic [((CONN_BITS+SEQ_BITS+7+7)/8)*8-1:0] in_tdata,
  // opcode
  input  logic [1:0] in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // slot_out, zero padded
  output logic [7:0] out_tdata,
  // success
  output logic out_tuser
);

  localparam int unsigned IDXW  = $clog2(SLOTS);
  localparam int unsigned CNTW  = $clog2(SLOTS + 1);
  localparam int unsigned SUMW  = CNTW + 1;
  localparam int unsigned SOB   = ort_pkg::SLOT_OUT_BITS;
  localparam int unsigned DATW  = CONN_BITS + SEQ_BITS + 1;
  localparam int unsigned SENTW = IDXW + DATW;
  localparam int unsigned SEQ_LO  = CONN_BITS;
  localparam int unsigned EXP_POS = CONN_BITS + SEQ_BITS;
  localparam int unsigned SIN_LO  = EXP_POS + 1;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_POST, S_TK1, S_TK2, S_SRCH, S_SHIFT, S_FREE, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  logic [CONN_BITS-1:0] conn_r;
  logic [SEQ_BITS-1:0]  seq_r;
  logic                 exp_r;
  logic [IDXW-1:0]      sidx_r;
  logic                 sok_r;
  logic [CNTW-1:0]      i_r, i_nxt;

  logic [IDXW-1:0] fhead_r, fhead_nxt, phead_r, phead_nxt;
  logic [CNTW-1:0] fcount_r, fcount_nxt, fwr_r, fwr_nxt;
  logic [CNTW-1:0] pcount_r, pcount_nxt, scount_r, scount_nxt;
  logic [CNTW-1:0] clr_r, clr_nxt;

  logic [IDXW-1:0] res_slot_r, res_slot_nxt;
  logic            res_ok_r, res_ok_nxt;
  logic            out_valid_r;
  logic [SOB-1:0]  out_slot_r;
  logic            out_ok_r;

  logic            in_fire;
  logic [1:0]      in_op;
  logic            out_free;

  // RAM ports
  logic            fifo_f_we, fifo_p_we, data_we, sent_we, stat_we;
  logic [IDXW-1:0] fifo_f_waddr, fifo_p_waddr, data_waddr, sent_waddr, stat_waddr;
  logic [IDXW-1:0] fifo_f_wdata, fifo_p_wdata;
  logic [DATW-1:0] data_wdata;
  logic [SENTW-1:0] sent_wdata;
  logic            stat_wdata;
  logic [IDXW-1:0] data_raddr, sent_raddr, stat_raddr;
  logic [IDXW-1:0] fifo_f_rdata, fifo_p_rdata;
  logic [DATW-1:0] data_rdata;
  logic [SENTW-1:0] sent_rdata;
  logic            stat_rdata;

  logic [SUMW-1:0] ftail_sum, ptail_sum;
  logic [IDXW-1:0] ftail, ptail;
  logic [IDXW-1:0] free_slot;
  logic [IDXW-1:0] ent_slot;
  logic            ent_match;
  logic [CNTW-1:0] i_inc, i_inc2;
  logic [IDXW+SOB-1:0] slot_in_wide;
  logic [IDXW+SOB-1:0] res_wide;

  assign in_op    = in_tuser;
  assign in_tready = (state_r == S_IDLE);
  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(8 - SOB){1'b0}}, out_slot_r};
  assign out_tuser  = out_ok_r;

  // Slot named by the incoming request, zero-extended so it can be compared with SLOTS.
  assign slot_in_wide = {{IDXW{1'b0}}, in_tdata[SIN_LO +: SOB]};
  assign res_wide     = {{SOB{1'b0}}, res_slot_r};

  assign ftail_sum = SUMW'(fhead_r) + SUMW'(fcount_r);
  assign ptail_sum = SUMW'(phead_r) + SUMW'(pcount_r);
  assign ftail = (ftail_sum >= SUMW'(SLOTS)) ? IDXW'(ftail_sum - SUMW'(SLOTS))
                                             : ftail_sum[IDXW-1:0];
  assign ptail = (ptail_sum >= SUMW'(SLOTS)) ? IDXW'(ptail_sum - SUMW'(SLOTS))
                                             : ptail_sum[IDXW-1:0];

  // Free-list positions at and beyond the write count still hold their reset index.
  assign free_slot = (CNTW'(fhead_r) < fwr_r) ? fifo_f_rdata : fhead_r;

  assign ent_slot  = sent_rdata[DATW +: IDXW];
  assign ent_match = (sent_rdata[DATW-1:0] == {exp_r, seq_r, conn_r});
  assign i_inc  = i_r + CNTW'(1);
  assign i_inc2 = i_r + CNTW'(2);

  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    fhead_nxt    = fhead_r;
    fcount_nxt   = fcount_r;
    fwr_nxt      = fwr_r;
    phead_nxt    = phead_r;
    pcount_nxt   = pcount_r;
    scount_nxt   = scount_r;
    clr_nxt      = clr_r;
    res_slot_nxt = res_slot_r;
    res_ok_nxt   = res_ok_r;

    fifo_f_we = 1'b0; fifo_f_waddr = ftail; fifo_f_wdata = sidx_r;
    fifo_p_we = 1'b0; fifo_p_waddr = ptail; fifo_p_wdata = free_slot;
    data_we   = 1'b0; data_waddr = free_slot; data_wdata = {exp_r, seq_r, conn_r};
    sent_we   = 1'b0; sent_waddr = scount_r[IDXW-1:0];
    sent_wdata = {fifo_p_rdata, data_rdata};
    stat_we   = 1'b0; stat_waddr = sidx_r; stat_wdata = 1'b0;
    data_raddr = fifo_p_rdata;
    sent_raddr = i_r[IDXW-1:0];
    stat_raddr = slot_in_wide[IDXW-1:0];

    unique case (state_r)
      S_CLR: begin
        stat_we    = 1'b1;
        stat_waddr = clr_r[IDXW-1:0];
        stat_wdata = 1'b0;
        clr_nxt    = clr_r + CNTW'(1);
        if (clr_r == CNTW'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        i_nxt      = '0;
        sent_raddr = '0;
        if (in_fire) begin
          unique case (in_op)
            ort_pkg::OP_POST: state_nxt = S_POST;
            ort_pkg::OP_TAKE: state_nxt = S_TK1;
            ort_pkg::OP_RESP: state_nxt = S_SRCH;
            ort_pkg::OP_FREE: state_nxt = S_FREE;
            default:          state_nxt = S_IDLE;
          endcase
        end
      end
      S_POST: begin
        state_nxt = S_OUT;
        if (fcount_r == '0 || pcount_r >= CNTW'(SLOTS)) begin
          res_ok_nxt = 1'b0;
        end else begin
          data_we      = 1'b1;
          fifo_p_we    = 1'b1;
          fhead_nxt    = (fhead_r == IDXW'(SLOTS - 1)) ? '0 : fhead_r + IDXW'(1);
          fcount_nxt   = fcount_r - CNTW'(1);
          pcount_nxt   = pcount_r + CNTW'(1);
          res_slot_nxt = free_slot;
          res_ok_nxt   = 1'b1;
        end
      end
      S_TK1: begin
        if (pcount_r == '0 || scount_r >= CNTW'(SLOTS)) begin
          res_ok_nxt = 1'b0;
          state_nxt  = S_OUT;
        end else begin
          state_nxt = S_TK2;
        end
      end
      S_TK2: begin
        sent_we      = 1'b1;
        phead_nxt    = (phead_r == IDXW'(SLOTS - 1)) ? '0 : phead_r + IDXW'(1);
        pcount_nxt   = pcount_r - CNTW'(1);
        scount_nxt   = scount_r + CNTW'(1);
        res_slot_nxt = fifo_p_rdata;
        res_ok_nxt   = 1'b1;
        state_nxt    = S_OUT;
      end
      S_SRCH: begin
        sent_raddr = i_inc[IDXW-1:0];
        if (i_r >= scount_r) begin
          res_ok_nxt = 1'b0;
          state_nxt  = S_OUT;
        end else if (ent_match) begin
          stat_we      = 1'b1;
          stat_waddr   = ent_slot;
          stat_wdata   = 1'b1;
          scount_nxt   = scount_r - CNTW'(1);
          res_slot_nxt = ent_slot;
          res_ok_nxt   = 1'b1;
          state_nxt    = S_SHIFT;
        end else begin
          i_nxt = i_inc;
        end
      end
      S_SHIFT: begin
        // The entry above the gap arrives; move it down one place.
        sent_raddr = i_inc2[IDXW-1:0];
        sent_waddr = i_r[IDXW-1:0];
        sent_wdata = sent_rdata;
        if (i_r < scount_r) begin
          sent_we = 1'b1;
          i_nxt   = i_inc;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_FREE: begin
        state_nxt = S_OUT;
        if (!sok_r || !stat_rdata || fcount_r >= CNTW'(SLOTS)) begin
          res_ok_nxt = 1'b0;
        end else begin
          stat_we      = 1'b1;
          stat_wdata   = 1'b0;
          fifo_f_we    = 1'b1;
          fcount_nxt   = fcount_r + CNTW'(1);
          fwr_nxt      = (fwr_r == CNTW'(SLOTS)) ? fwr_r : fwr_r + CNTW'(1);
          res_slot_nxt = sidx_r;
          res_ok_nxt   = 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      fhead_r     <= '0;
      fcount_r    <= CNTW'(SLOTS);
      fwr_r       <= '0;
      phead_r     <= '0;
      pcount_r    <= '0;
      scount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      fhead_r  <= fhead_nxt;
      fcount_r <= fcount_nxt;
      fwr_r    <= fwr_nxt;
      phead_r  <= phead_nxt;
      pcount_r <= pcount_nxt;
      scount_r <= scount_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    res_slot_r <= res_slot_nxt;
    res_ok_r   <= res_ok_nxt;
    if (in_fire) begin
      conn_r <= in_tdata[CONN_BITS-1:0];
      seq_r  <= in_tdata[SEQ_LO +: SEQ_BITS];
      exp_r  <= in_tdata[EXP_POS];
      sidx_r <= slot_in_wide[IDXW-1:0];
      sok_r  <= (slot_in_wide < (IDXW + SOB)'(SLOTS));
    end
    if (state_r == S_OUT && out_free) begin
      out_slot_r <= res_ok_r ? res_wide[SOB-1:0] : '0;
      out_ok_r   <= res_ok_r;
    end
  end

  ort_ram #(.WIDTH(IDXW), .DEPTH(SLOTS)) u_free_fifo (
    .clk(clk), .we(fifo_f_we), .waddr(fifo_f_waddr), .wdata(fifo_f_wdata),
    .raddr(fhead_r), .rdata_r(fifo_f_rdata)
  );

  ort_ram #(.WIDTH(IDXW), .DEPTH(SLOTS)) u_posted_fifo (
    .clk(clk), .we(fifo_p_we), .waddr(fifo_p_waddr), .wdata(fifo_p_wdata),
    .raddr(phead_r), .rdata_r(fifo_p_rdata)
  );

  ort_ram #(.WIDTH(DATW), .DEPTH(SLOTS)) u_slot_data (
    .clk(clk), .we(data_we), .waddr(data_waddr), .wdata(data_wdata),
    .raddr(data_raddr), .rdata_r(data_rdata)
  );

  ort_ram #(.WIDTH(SENTW), .DEPTH(SLOTS)) u_sent_list (
    .clk(clk), .we(sent_we), .waddr(sent_waddr), .wdata(sent_wdata),
    .raddr(sent_raddr), .rdata_r(sent_rdata)
  );

  ort_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_responded (
    .clk(clk), .we(stat_we), .waddr(stat_waddr), .wdata(stat_wdata),
    .raddr(stat_raddr), .rdata_r(stat_rdata)
  );

`ifndef SYNTHESIS
  // The free, posted and sent list counts together never exceed SLOTS.
  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (SUMW + 1)'(fcount_r) + (SUMW + 1)'(pcount_r) + (SUMW + 1)'(scount_r)
      <= (SUMW + 1)'(SLOTS))
    else $error("slot lists hold more than SLOTS entries");

  // A failed request always reports slot zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("failed request reports a non-zero slot");

  // The clearing pass runs with every slot still free.
  a_clr_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> (fcount_r == CNTW'(SLOTS) && pcount_r == '0))
    else $error("slot lists changed during the clearing pass");

  // Closing the gap only runs after a match has shortened the sent list.
  a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (i_r <= scount_r))
    else $error("sent list compaction ran past the list end");
`endif

endmodule
